>>> rtl/ndg_pkg.sv
package ndg_pkg;

	// Grid shape
	localparam int DIMENSIONS = 2;
	localparam int MAX_SIDE   = 64;
	localparam int AXES       = 4;

	// Fixed field widths
	localparam int COORD_W    = 6;
	localparam int SIDE_W     = 7;
	localparam int COUNT_W    = 7;
	localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd64;

	// Derived sizes
	localparam int AXIS_W   = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int DEPTH    = MAX_SIDE ** DIMENSIONS;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int WIN_SIZE = 3 ** DIMENSIONS;
	localparam int CNT_W    = $clog2(WIN_SIZE);

	// Request modes
	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_COUNT = 2'd2;

	// Window step per axis: below, on, above the centre
	localparam logic [1:0] STEP_DOWN = 2'd0;
	localparam logic [1:0] STEP_ON   = 2'd1;
	localparam logic [1:0] STEP_UP   = 2'd2;

	typedef logic [1:0]                            mode_t;
	typedef logic [AXIS_W-1:0]                     axis_t;
	typedef logic [DIMENSIONS-1:0][AXIS_W-1:0]     axis_vec_t;
	typedef logic [DIMENSIONS-1:0][1:0]            digit_vec_t;
	typedef logic [ADDR_W-1:0]                     addr_t;

	// Controller to datapath
	typedef struct packed {
		logic take;        // ready for a request
		logic clear;       // clearing pass write
		logic write;       // store new alive bit
		logic read_centre; // read the addressed cell
		logic scan;        // read one window cell, step the window
		logic out_load;    // move result into the output register
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic  in_valid;
		mode_t in_mode;
		logic  in_err;
		logic  clr_last;
		logic  scan_last;
		logic  out_free;
	} status_t;

	// Linear cell address: sum of coord_k * MAX_SIDE^k
	function automatic addr_t cell_addr(input axis_vec_t p);
		addr_t a;
		a = '0;
		for (int k = DIMENSIONS - 1; k >= 0; k--) begin
			a = ADDR_W'(a * MAX_SIDE) + ADDR_W'(p[k]);
		end
		return a;
	endfunction

endpackage

>>> rtl/ndg_if.sv
interface ndg_in_if import ndg_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic [COORD_W-1:0] coord_0;
	logic [COORD_W-1:0] coord_1;
	logic [COORD_W-1:0] coord_2;
	logic [COORD_W-1:0] coord_3;
	logic               new_alive;

	modport source (output valid, mode, coord_0, coord_1, coord_2, coord_3, new_alive,
		input ready);
	modport sink (input valid, mode, coord_0, coord_1, coord_2, coord_3, new_alive,
		output ready);
endinterface

interface ndg_out_if import ndg_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               alive;
	logic [COUNT_W-1:0] neighbor_count;
	logic               coord_error;

	modport source (output valid, alive, neighbor_count, coord_error, input ready);
	modport sink (input valid, alive, neighbor_count, coord_error, output ready);
endinterface

>>> rtl/nd_grid_live_neighbor_count.sv
// Channel   Dir  Handshake     Payload
// item      in   valid/ready   mode, coord_0..coord_3, new_alive
// result    out  valid/ready   alive, neighbor_count, coord_error
// cfg       in   cfg_we        cfg_wdata (side_length)
//
// A neighbour count walks the window through the single read port of the
// cell memory, which visits one window cell per cycle.
// After reset a clearing pass zeroes the memory; no request is taken
// meanwhile, side_length writes are.
// A stalled result waits in the output register while the next request is
// taken; that request finishes once the register is free.
module nd_grid_live_neighbor_count import ndg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	ndg_in_if.sink            item,
	ndg_out_if.source         result,
	input  logic              cfg_we,
	input  logic [SIDE_W-1:0] cfg_wdata
);

	cmd_t    cmd;
	status_t st;

	// Sequencer
	ndg_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cmd    (cmd)
	);

	// Cell store, window walk and result register
	ndg_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.st        (st)
	);

endmodule

>>> rtl/ndg_ctrl.sv
module ndg_ctrl import ndg_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  status_t st,
	output cmd_t    cmd
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_WRITE = 3'd2;
	localparam logic [2:0] S_READ  = 3'd3;
	localparam logic [2:0] S_SCAN  = 3'd4;
	localparam logic [2:0] S_DRAIN = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (st.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (st.in_valid) begin
					if (st.in_err) begin
						state_d = S_DONE;
					end else begin
						case (st.in_mode)
							MODE_WRITE: state_d = S_WRITE;
							MODE_COUNT: state_d = S_SCAN;
							default:    state_d = S_READ;
						endcase
					end
				end
			end
			S_WRITE: state_d = S_DONE;
			S_READ:  state_d = S_DRAIN;
			S_SCAN: begin
				if (st.scan_last) state_d = S_DRAIN;
			end
			S_DRAIN: state_d = S_DONE;
			S_DONE: begin
				if (st.out_free) state_d = S_IDLE;
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Commands
	always_comb begin
		cmd             = '0;
		cmd.take        = (state_q == S_IDLE);
		cmd.clear       = (state_q == S_CLEAR);
		cmd.write       = (state_q == S_WRITE);
		cmd.read_centre = (state_q == S_READ);
		cmd.scan        = (state_q == S_SCAN);
		cmd.out_load    = (state_q == S_DONE) && st.out_free;
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> st.out_free)
		else $error("result loaded into a full output register");

	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) && st.scan_last |=> (state_q == S_DRAIN))
		else $error("window scan did not end in drain");

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> !cmd.take && !cmd.out_load)
		else $error("request taken during clearing pass");

endmodule

>>> rtl/ndg_dp.sv
module ndg_dp import ndg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	ndg_in_if.sink            item,
	ndg_out_if.source         result,
	input  logic              cfg_we,
	input  logic [SIDE_W-1:0] cfg_wdata,
	input  cmd_t              cmd,
	output status_t           st
);

	// Cell memory, one alive bit per cell
	logic mem [DEPTH];

	logic [SIDE_W-1:0]  side_q;
	logic [SIDE_W-1:0]  eff_side;
	logic [COORD_W-1:0] coord_in [AXES];
	logic               in_err;
	logic               load;

	axis_vec_t          pos_q;
	logic               new_alive_q;
	logic               err_q;
	digit_vec_t         dig_q;
	digit_vec_t         dig_d;
	addr_t              clr_q;

	axis_vec_t          probe;
	logic               probe_in;
	logic               probe_ctr;
	logic               scan_last;

	logic               we;
	addr_t              waddr;
	logic               wdata;
	addr_t              raddr;

	logic               rd_s1;
	logic               cnt_s1;
	logic               ctr_s1;

	logic [CNT_W-1:0]   cnt_q;
	logic               alive_q;

	logic               out_valid_q;
	logic               res_alive_q;
	logic [COUNT_W-1:0] res_cnt_q;
	logic               res_err_q;

	// Side register and its saturated value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= SIDE_RESET;
		end else if (cfg_we) begin
			side_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (side_q == '0) begin
			eff_side = SIDE_W'(1);
		end else if (side_q > SIDE_W'(MAX_SIDE)) begin
			eff_side = SIDE_W'(MAX_SIDE);
		end else begin
			eff_side = side_q;
		end
	end

	// Range check of the incoming request
	assign coord_in[0] = item.coord_0;
	assign coord_in[1] = item.coord_1;
	assign coord_in[2] = item.coord_2;
	assign coord_in[3] = item.coord_3;

	always_comb begin
		in_err = 1'b0;
		for (int k = 0; k < DIMENSIONS; k++) begin
			if (SIDE_W'(coord_in[k]) >= eff_side) in_err = 1'b1;
		end
	end

	assign load = cmd.take && item.valid;

	// Request capture
	always_ff @(posedge clk) begin
		if (load) begin
			for (int k = 0; k < DIMENSIONS; k++) begin
				pos_q[k] <= AXIS_W'(coord_in[k]);
			end
			new_alive_q <= item.new_alive;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q <= 1'b0;
		end else if (load) begin
			err_q <= in_err;
		end
	end

	// Window probe from the step digits
	always_comb begin
		probe_in  = 1'b1;
		probe_ctr = 1'b1;
		scan_last = 1'b1;
		probe     = pos_q;
		for (int k = 0; k < DIMENSIONS; k++) begin
			if (dig_q[k] != STEP_ON) probe_ctr = 1'b0;
			if (dig_q[k] != STEP_UP) scan_last = 1'b0;
			case (dig_q[k])
				STEP_DOWN: begin
					if (pos_q[k] == '0) probe_in = 1'b0;
					probe[k] = pos_q[k] - AXIS_W'(1);
				end
				STEP_UP: begin
					if (SIDE_W'(pos_q[k]) + SIDE_W'(1) >= eff_side) probe_in = 1'b0;
					probe[k] = pos_q[k] + AXIS_W'(1);
				end
				default: probe[k] = pos_q[k];
			endcase
		end
	end

	// Step digits advance as a base-three counter
	always_comb begin
		logic carry;
		carry = 1'b1;
		dig_d = dig_q;
		for (int k = 0; k < DIMENSIONS; k++) begin
			if (carry) begin
				if (dig_q[k] == STEP_UP) begin
					dig_d[k] = STEP_DOWN;
				end else begin
					dig_d[k] = dig_q[k] + 2'd1;
					carry    = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_q <= '0;
		end else if (load) begin
			dig_q <= '0;
		end else if (cmd.scan) begin
			dig_q <= dig_d;
		end
	end

	// Clearing pass address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + ADDR_W'(1);
		end
	end

	// Memory port selection
	assign we    = cmd.clear || cmd.write;
	assign waddr = cmd.clear ? clr_q : cell_addr(pos_q);
	assign wdata = cmd.clear ? 1'b0 : new_alive_q;
	assign raddr = cmd.scan ? cell_addr(probe) : cell_addr(pos_q);

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_s1 <= mem[raddr];
	end

	// Read stage flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s1 <= 1'b0;
			ctr_s1 <= 1'b0;
		end else begin
			cnt_s1 <= cmd.scan && probe_in && !probe_ctr;
			ctr_s1 <= cmd.read_centre || (cmd.scan && probe_ctr);
		end
	end

	// Count and alive accumulation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			alive_q <= 1'b0;
		end else if (load) begin
			cnt_q   <= '0;
			alive_q <= 1'b0;
		end else begin
			if (cnt_s1 && rd_s1) cnt_q <= cnt_q + CNT_W'(1);
			if (ctr_s1) alive_q <= rd_s1;
			if (cmd.write) alive_q <= new_alive_q;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_alive_q <= alive_q;
			res_cnt_q   <= COUNT_W'(cnt_q);
			res_err_q   <= err_q;
		end
	end

	assign item.ready            = cmd.take;
	assign result.valid          = out_valid_q;
	assign result.alive          = res_alive_q;
	assign result.neighbor_count = res_cnt_q;
	assign result.coord_error    = res_err_q;

	// Status back to the controller
	always_comb begin
		st           = '0;
		st.in_valid  = item.valid;
		st.in_mode   = item.mode;
		st.in_err    = in_err;
		st.clr_last  = (clr_q == ADDR_W'(DEPTH - 1));
		st.scan_last = scan_last;
		st.out_free  = !out_valid_q || result.ready;
	end

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load && err_q |-> !alive_q && (cnt_q == '0))
		else $error("range error result carries data");

	a_no_bad_write: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write |-> !err_q)
		else $error("store written for an out-of-range request");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (32'(cnt_q) < WIN_SIZE))
		else $error("neighbour count beyond window size");

endmodule

>>> tb/nd_grid_live_neighbor_count_test.sv
`timescale 1ns / 100ps

module nd_grid_live_neighbor_count_test;
	import ndg_pkg::*;

	localparam mode_t       MODE_SPARE     = 2'd3; // undefined mode, behaves as a read
	localparam int          PHASES         = 11;
	localparam int          HOLD_CYCLES    = 300;
	localparam int          WATCHDOG_LIMIT = 20000;
	localparam int          TAIL_CYCLES    = 40;

	typedef struct packed {
		mode_t                         mode;
		logic [AXES-1:0][COORD_W-1:0]  coord;
		logic                          new_alive;
	} request_t;

	typedef struct packed {
		logic               alive;
		logic [COUNT_W-1:0] neighbor_count;
		logic               coord_error;
	} grid_result_t;

	typedef enum {PACE_FULL, PACE_SENDER_IDLE, PACE_RECEIVER_STALL, PACE_BOTH} pace_t;

	// Grid model and queue of outstanding results
	class live_cell_tracker;
		bit                cells [DEPTH];
		logic [SIDE_W-1:0] side_reg;
		grid_result_t      awaited [$];
		int unsigned       errors;
		int unsigned       requests;
		int unsigned       counts;
		int unsigned       flagged;

		function new();
			side_reg = SIDE_RESET;
			foreach (cells[i]) cells[i] = 1'b0;
			errors   = 0;
			requests = 0;
			counts   = 0;
			flagged  = 0;
		endfunction

		// Side in force, saturated to 1..MAX_SIDE
		function int unsigned used_side();
			if (side_reg == 0) return 1;
			if (side_reg > MAX_SIDE) return MAX_SIDE;
			return side_reg;
		endfunction

		function int unsigned cell_index(int unsigned pos [AXES]);
			int unsigned idx;
			int unsigned scale;
			idx   = 0;
			scale = 1;
			for (int k = 0; k < DIMENSIONS; k++) begin
				idx   += pos[k] * scale;
				scale *= MAX_SIDE;
			end
			return idx % DEPTH;
		endfunction

		// Live cells in the window round pos, centre and off-grid cells skipped
		function int unsigned live_around(int unsigned pos [AXES], int unsigned side);
			int unsigned probe [AXES];
			int unsigned rest;
			int unsigned step;
			int unsigned live;
			bit          centre;
			bit          on_grid;
			live = 0;
			for (int combo = 0; combo < WIN_SIZE; combo++) begin
				rest    = combo;
				centre  = 1'b1;
				on_grid = 1'b1;
				probe   = pos;
				for (int k = 0; k < DIMENSIONS; k++) begin
					step = rest % 3;
					rest = rest / 3;
					if (step != STEP_ON) centre = 1'b0;
					if (step == STEP_DOWN) begin
						if (pos[k] == 0) on_grid = 1'b0;
						else probe[k] = pos[k] - 1;
					end else if (step == STEP_UP) begin
						if (pos[k] + 1 >= side) on_grid = 1'b0;
						else probe[k] = pos[k] + 1;
					end
				end
				if (!centre && on_grid) live += cells[cell_index(probe)];
			end
			return live;
		endfunction

		function grid_result_t predict(request_t req);
			grid_result_t res;
			int unsigned  pos [AXES];
			int unsigned  side;
			int unsigned  idx;
			bit           bad;
			res  = '0;
			side = used_side();
			bad  = 1'b0;
			for (int k = 0; k < AXES; k++) pos[k] = req.coord[k];
			for (int k = 0; k < DIMENSIONS; k++) if (pos[k] >= side) bad = 1'b1;
			if (bad) begin
				res.coord_error = 1'b1;
				flagged++;
				return res;
			end
			idx = cell_index(pos);
			if (req.mode == MODE_WRITE) begin
				cells[idx] = req.new_alive;
			end else if (req.mode == MODE_COUNT) begin
				res.neighbor_count = COUNT_W'(live_around(pos, side));
				counts++;
			end
			res.alive = cells[idx];
			return res;
		endfunction

		function void note_request(request_t req);
			grid_result_t res;
			requests++;
			res = predict(req);
			awaited.insert(awaited.size(), res);
		endfunction

		function void check_result(grid_result_t got);
			grid_result_t want;
			if (awaited.size() == 0) begin
				$display("%0t: result with no request outstanding: alive %0d count %0d error %0d",
					$time, got.alive, got.neighbor_count, got.coord_error);
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (got.alive !== want.alive) begin
				$display("%0t: alive expected %0d actual %0d", $time, want.alive, got.alive);
				errors++;
			end
			if (got.neighbor_count !== want.neighbor_count) begin
				$display("%0t: neighbor_count expected %0d actual %0d", $time,
					want.neighbor_count, got.neighbor_count);
				errors++;
			end
			if (got.coord_error !== want.coord_error) begin
				$display("%0t: coord_error expected %0d actual %0d", $time,
					want.coord_error, got.coord_error);
				errors++;
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [SIDE_W-1:0] cfg_wdata;

	ndg_in_if  item_ch ();
	ndg_out_if result_ch ();

	nd_grid_live_neighbor_count dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	live_cell_tracker tracker = new();
	pace_t            pace = PACE_FULL;
	bit               hold_request = 1'b0;
	int unsigned      quiet_cycles = 0;
	int unsigned      hot [AXES];

	int unsigned phase_side  [PHASES] = '{64, 8, 3, 0, 1, 127, 2, 64, 5, 100, 13};
	int unsigned phase_items [PHASES] = '{150, 150, 120, 40, 40, 150, 100, 200, 150, 150, 100};
	pace_t       phase_pace  [PHASES] = '{PACE_FULL, PACE_SENDER_IDLE, PACE_RECEIVER_STALL,
		PACE_BOTH, PACE_FULL, PACE_FULL, PACE_BOTH, PACE_RECEIVER_STALL, PACE_SENDER_IDLE,
		PACE_BOTH, PACE_FULL};

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit chance(int unsigned pct);
		return $urandom_range(99, 0) < pct;
	endfunction

	// Request monitor feeds the model
	always @(posedge clk) begin : request_monitor
		request_t r;
		if (arst_n && item_ch.valid && item_ch.ready) begin
			r.mode      = item_ch.mode;
			r.coord[0]  = item_ch.coord_0;
			r.coord[1]  = item_ch.coord_1;
			r.coord[2]  = item_ch.coord_2;
			r.coord[3]  = item_ch.coord_3;
			r.new_alive = item_ch.new_alive;
			tracker.note_request(r);
		end
	end

	// Result monitor
	always @(posedge clk) begin : result_monitor
		grid_result_t g;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			g.alive          = result_ch.alive;
			g.neighbor_count = result_ch.neighbor_count;
			g.coord_error    = result_ch.coord_error;
			tracker.check_result(g);
		end
	end

	// Watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Result receiver: random stalls, plus one long hold-off on request
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				result_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end
			case (pace)
				PACE_RECEIVER_STALL: result_ch.ready = !chance(77);
				PACE_BOTH:           result_ch.ready = !chance(18);
				default:             result_ch.ready = 1'b1;
			endcase
		end
	end

	// Offer one request and hold it until taken; returns at a falling edge
	task automatic send_request(request_t req);
		int unsigned idle_pct;
		idle_pct = (pace == PACE_SENDER_IDLE) ? 77 : (pace == PACE_BOTH) ? 18 : 0;
		while (chance(idle_pct)) begin
			item_ch.valid = 1'b0;
			@(negedge clk);
		end
		item_ch.valid     = 1'b1;
		item_ch.mode      = req.mode;
		item_ch.coord_0   = req.coord[0];
		item_ch.coord_1   = req.coord[1];
		item_ch.coord_2   = req.coord[2];
		item_ch.coord_3   = req.coord[3];
		item_ch.new_alive = req.new_alive;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Directed request at (x, y); the ignored axes carry random bits
	task automatic issue(mode_t mode, int unsigned x, int unsigned y, bit alive_bit);
		request_t req;
		req.mode      = mode;
		req.coord[0]  = COORD_W'(x);
		req.coord[1]  = COORD_W'(y);
		req.coord[2]  = COORD_W'($urandom_range(63, 0));
		req.coord[3]  = COORD_W'($urandom_range(63, 0));
		req.new_alive = alive_bit;
		send_request(req);
	endtask

	// Mostly near the phase's hot spot so that windows hold live cells
	function automatic logic [COORD_W-1:0] pick_coord(int unsigned side, int unsigned centre);
		int          v;
		int unsigned roll;
		roll = $urandom_range(99, 0);
		if (roll < 65) begin
			v = int'(centre) + int'($urandom_range(4, 0)) - 2;
			if (v < 0) v = 0;
			if (v > int'(side) - 1) v = int'(side) - 1;
		end else if (roll < 82) begin
			v = $urandom_range(side - 1, 0);
		end else if (roll < 92) begin
			v = $urandom_range(63, 0);
		end else begin
			v = chance(50) ? 0 : int'(side) - 1;
		end
		return COORD_W'(v);
	endfunction

	function automatic request_t random_request(int unsigned side);
		request_t    req;
		int unsigned roll;
		roll = $urandom_range(99, 0);
		if (roll < 40)      req.mode = MODE_WRITE;
		else if (roll < 60) req.mode = MODE_READ;
		else if (roll < 95) req.mode = MODE_COUNT;
		else                req.mode = MODE_SPARE;
		for (int k = 0; k < AXES; k++) begin
			if (k < DIMENSIONS) req.coord[k] = pick_coord(side, hot[k]);
			else req.coord[k] = COORD_W'($urandom_range(63, 0));
		end
		req.new_alive = chance(70);
		return req;
	endfunction

	// Wait until every result has come back
	task automatic settle();
		item_ch.valid = 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
	endtask

	// Side register write while the block is idle
	task automatic write_side(int unsigned value);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = SIDE_W'(value);
		@(negedge clk);
		cfg_we    = 1'b0;
		tracker.side_reg = SIDE_W'(value);
	endtask

	// Main sequence
	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = '0;
		item_ch.valid     = 1'b0;
		item_ch.mode      = MODE_READ;
		item_ch.coord_0   = '0;
		item_ch.coord_1   = '0;
		item_ch.coord_2   = '0;
		item_ch.coord_3   = '0;
		item_ch.new_alive = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int p = 0; p < PHASES; p++) begin
			// the first phase runs on the reset value of the side
			if (p != 0) begin
				settle();
				write_side(phase_side[p]);
			end
			pace = phase_pace[p];
			for (int k = 0; k < AXES; k++) hot[k] = $urandom_range(tracker.used_side() - 1, 0);

			case (p)
				0: begin
					// corners, the undefined mode, and a fully live window
					issue(MODE_READ, 0, 0, 1'b0);
					issue(MODE_WRITE, 0, 0, 1'b1);
					issue(MODE_WRITE, 63, 63, 1'b1);
					issue(MODE_WRITE, 0, 63, 1'b1);
					issue(MODE_WRITE, 63, 0, 1'b1);
					issue(MODE_SPARE, 63, 63, 1'b0);
					issue(MODE_COUNT, 0, 0, 1'b0);
					issue(MODE_COUNT, 63, 63, 1'b0);
					issue(MODE_COUNT, 62, 62, 1'b0);
					for (int dx = 0; dx < 3; dx++)
						for (int dy = 0; dy < 3; dy++)
							issue(MODE_WRITE, 39 + dx, 39 + dy, 1'b1);
					issue(MODE_COUNT, 40, 40, 1'b0);
					issue(MODE_WRITE, 40, 40, 1'b0);
					issue(MODE_COUNT, 41, 41, 1'b0);
				end
				1: begin
					// shrunk side: edge of the grid and out-of-range requests
					issue(MODE_WRITE, 7, 7, 1'b1);
					issue(MODE_COUNT, 7, 7, 1'b0);
					issue(MODE_COUNT, 8, 0, 1'b0);
					issue(MODE_READ, 0, 63, 1'b0);
					issue(MODE_WRITE, 63, 63, 1'b0);
					issue(MODE_COUNT, 7, 6, 1'b0);
				end
				3: begin
					// side of zero behaves as one
					issue(MODE_COUNT, 0, 0, 1'b0);
					issue(MODE_WRITE, 1, 0, 1'b1);
				end
				5: begin
					// oversized side saturates; cells kept while hidden reappear
					hold_request = 1'b1;
					issue(MODE_READ, 40, 41, 1'b0);
					issue(MODE_COUNT, 40, 40, 1'b0);
					issue(MODE_READ, 63, 63, 1'b0);
				end
				default: ;
			endcase

			for (int i = 0; i < phase_items[p]; i++)
				send_request(random_request(tracker.used_side()));
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Ran %0d requests over %0d side settings: %0d neighbour counts, %0d out of range.",
			tracker.requests, PHASES, tracker.counts, tracker.flagged);
		$display("Mismatches: %0d, results outstanding: %0d", tracker.errors, tracker.pending());
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
